/* sv/seba_pkg.sv */
// Shared types, constants and the easing factor table for the spectrum bar animator.
package seba_pkg;

    // Request codes on req_type
    localparam logic REQ_TICK    = 1'b0;
    localparam logic REQ_PRESENT = 1'b1;

    // Easing length in ticks; the factor table below is built for this value
    localparam int unsigned STEPS = 20;
    localparam logic [4:0]  STEP_LIMIT = 5'(STEPS);

    // Level = value * 8 / 90, done as (value * 2913) >> 15 for values below 128
    localparam logic [11:0] LEVEL_MUL   = 12'd2913;
    localparam int unsigned LEVEL_SHIFT = 15;
    localparam logic [3:0]  MAX_LEVEL   = 4'd11;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_TICK
    } seq_state_t;

    // One bar's state as held in the bar memory
    typedef struct packed {
        logic [6:0] start;
        logic [6:0] goal;
        logic [4:0] step;
    } bar_entry_t;

    // 1 - exp(-3*step/STEPS) in unsigned Q0.16
    function automatic logic [15:0] ease_factor(input logic [4:0] step);
        logic [15:0] f;
        case (step)
            5'd0:    f = 16'd0;
            5'd1:    f = 16'd9129;
            5'd2:    f = 16'd16986;
            5'd3:    f = 16'd23748;
            5'd4:    f = 16'd29569;
            5'd5:    f = 16'd34579;
            5'd6:    f = 16'd38891;
            5'd7:    f = 16'd42602;
            5'd8:    f = 16'd45797;
            5'd9:    f = 16'd48546;
            5'd10:   f = 16'd50913;
            5'd11:   f = 16'd52950;
            5'd12:   f = 16'd54703;
            5'd13:   f = 16'd56212;
            5'd14:   f = 16'd57511;
            5'd15:   f = 16'd58629;
            5'd16:   f = 16'd59591;
            5'd17:   f = 16'd60419;
            5'd18:   f = 16'd61132;
            5'd19:   f = 16'd61745;
            default: f = 16'd0;
        endcase
        return f;
    endfunction

endpackage

/* sv/spectrum_bar_easing_animator_unit.sv */
// Spectrum bar easing animator: bar memory, tick sequencer and easing pipeline.
//
// Keeps BARS display bars (1 to 16) in one synchronous memory of {start, goal, step}
// words, read through a registered read port. A present word (req_type = 1) reads
// the addressed bar and writes it back in the following cycle with start = old
// goal, goal = bar_value and step = 0; it gives no result, and a bar index of BARS
// or above is dropped. A tick word (req_type = 0) walks the bars in index order,
// issuing one memory read per cycle while the output is not stalled: each bar is
// eased along 1 - exp(-3*step/20) from the factor table, written back with its
// step advanced (or with start = goal once the step count is used up) and reported
// as a level of value*8/90. Behind the reads sit two further stages (multiply,
// scale), and the last result of a tick carries last_bar. Results stream out one
// per cycle while out_stall is low; a stall freezes the whole tick pipeline, memory
// read register included. New words are refused until the last bar of a tick has
// reached the output register, so a present never overlaps a tick's write-back and
// the memory needs no forwarding. Bar state resets to zero through per-entry valid
// bits, so no clearing pass follows reset.
module spectrum_bar_easing_animator_unit
    import seba_pkg::*;
#(
    parameter int unsigned BARS = 12
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       req_type,
    input  logic [3:0] bar_index,
    input  logic [6:0] bar_value,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] out_bar,
    output logic [3:0] bar_level,
    output logic       last_bar
);

    localparam int unsigned AW = (BARS > 1) ? $clog2(BARS) : 1;
    localparam logic [AW-1:0] LAST_IDX  = AW'(BARS - 1);
    localparam logic [4:0]    BAR_LIMIT = 5'(BARS);

    // Control state
    seq_state_t    state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [BARS-1:0] vld_reg;
    logic          rd_vld_reg;
    logic          s1_valid_reg;
    logic          s2_valid_reg;
    logic          out_valid_reg;

    // Payload
    bar_entry_t    mem [BARS];
    bar_entry_t    rd_data_reg;
    logic [AW-1:0] load_addr_reg;
    logic [6:0]    load_value_reg;
    logic [AW-1:0] s1_bar_reg;
    logic          s1_last_reg;
    logic [AW-1:0] s2_bar_reg;
    logic          s2_last_reg;
    logic [6:0]    s2_base_reg;
    logic [6:0]    s2_delta_reg;
    logic          s2_down_reg;
    logic [3:0]    out_bar_reg;
    logic [3:0]    bar_level_reg;
    logic          last_bar_reg;

    // Memory port controls
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    bar_entry_t    wr_data;

    logic          en;
    logic          in_acc;
    bar_entry_t    rd_entry;

    // Stage 1 arithmetic
    logic          active;
    logic          rising;
    logic [6:0]    diff;
    logic [15:0]   factor;
    logic [22:0]   product;

    // Stage 2 arithmetic
    logic [6:0]    shown;
    logic [18:0]   scaled;

    // Whole tick pipeline moves unless the output word is held
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = (state_reg != ST_IDLE) || s1_valid_reg || s2_valid_reg;
    assign in_acc   = in_valid && !in_stall;

    // Never-written bars read as zero
    assign rd_entry = rd_vld_reg ? rd_data_reg : '0;

    // Easing of the bar in stage 1
    assign active  = rd_entry.step < STEP_LIMIT;
    assign rising  = rd_entry.goal >= rd_entry.start;
    assign diff    = rising ? (rd_entry.goal - rd_entry.start)
                            : (rd_entry.start - rd_entry.goal);
    assign factor  = ease_factor(rd_entry.step);
    assign product = {16'b0, diff} * {7'b0, factor};

    // Level scaling in stage 2
    assign shown  = s2_down_reg ? (s2_base_reg - s2_delta_reg)
                                : (s2_base_reg + s2_delta_reg);
    assign scaled = {12'b0, shown} * {7'b0, LEVEL_MUL};

    // Sequencer and memory port control
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        rd_en      = 1'b0;
        rd_addr    = idx_reg;
        wr_en      = 1'b0;
        wr_addr    = s1_bar_reg;
        wr_data    = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (req_type == REQ_PRESENT)
                    begin
                        if ({1'b0, bar_index} < BAR_LIMIT)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = bar_index[AW-1:0];
                            state_next = ST_LOAD;
                        end
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = ST_TICK;
                    end
                end
            end
            ST_LOAD:
            begin
                wr_en         = 1'b1;
                wr_addr       = load_addr_reg;
                wr_data.start = rd_entry.goal;
                wr_data.goal  = load_value_reg;
                wr_data.step  = '0;
                state_next    = ST_IDLE;
            end
            ST_TICK:
            begin
                if (en)
                begin
                    rd_en = 1'b1;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + AW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Tick write-back; never coincides with a load (pipeline is empty then)
        if (s1_valid_reg && en)
        begin
            wr_en   = 1'b1;
            wr_addr = s1_bar_reg;
            if (active)
            begin
                wr_data.start = rd_entry.start;
                wr_data.goal  = rd_entry.goal;
                wr_data.step  = rd_entry.step + 5'd1;
            end
            else
            begin
                wr_data.start = rd_entry.goal;
                wr_data.goal  = rd_entry.goal;
                wr_data.step  = rd_entry.step;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            vld_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
            if (en)
            begin
                s1_valid_reg  <= (state_reg == ST_TICK);
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Bar memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            load_addr_reg  <= bar_index[AW-1:0];
            load_value_reg <= bar_value;
        end
        if (en)
        begin
            s1_bar_reg    <= idx_reg;
            s1_last_reg   <= (idx_reg == LAST_IDX);
            s2_bar_reg    <= s1_bar_reg;
            s2_last_reg   <= s1_last_reg;
            s2_base_reg   <= active ? rd_entry.start : rd_entry.goal;
            s2_delta_reg  <= active ? product[22:16] : 7'd0;
            s2_down_reg   <= active && !rising;
            out_bar_reg   <= 4'(s2_bar_reg);
            bar_level_reg <= scaled[LEVEL_SHIFT+3:LEVEL_SHIFT];
            last_bar_reg  <= s2_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_bar   = out_bar_reg;
    assign bar_level = bar_level_reg;
    assign last_bar  = last_bar_reg;

endmodule

/* sv/seba_checker.sv */
// Port-level assertions for the spectrum bar animator, bound to the top level.
module seba_checker
    import seba_pkg::*;
#(
    parameter int unsigned BARS = 12
) (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [3:0] out_bar,
    input logic [3:0] bar_level,
    input logic       last_bar
);

    localparam logic [3:0] LAST_BAR = 4'(BARS - 1);

    // Held result word stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_bar) &&
            $stable(bar_level) && $stable(last_bar))
        else $error("result word changed under stall");

    a_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> bar_level <= MAX_LEVEL)
        else $error("bar level out of range");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_bar |-> out_bar == LAST_BAR)
        else $error("last_bar on wrong bar");

    // Tick results stream without gaps, in bar order
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_bar |=>
            out_valid && out_bar == 4'($past(out_bar) + 4'd1))
        else $error("tick results out of order or gapped");

    // No new word while a tick is still being reported
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_bar |-> in_stall)
        else $error("input taken mid-tick");

endmodule

bind spectrum_bar_easing_animator_unit seba_checker #(.BARS(BARS)) u_seba_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_bar   (out_bar),
    .bar_level (bar_level),
    .last_bar  (last_bar)
);

/* tb/sv/tb_spectrum_bar_easing_animator_unit.sv */
// Self-checking testbench for the spectrum bar easing animator: predictor, stimulus and checks.
`timescale 1ns / 100ps

module tb_spectrum_bar_easing_animator_unit
    import seba_pkg::*;
();

    localparam int unsigned NUM_BARS     = 12;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned RANDOM_WORDS = 370;
    // Three pipeline stages to the last result, plus a good margin
    localparam int unsigned DRAIN_CYCLES = 30;

    // One reported bar, as it should appear on the result port
    typedef struct packed {
        logic [3:0] bar;
        logic [3:0] level;
        logic       last;
    } level_rec_t;

    // Tracks bar state and the levels still owed by the block.
    class bar_anim_board;
        logic [6:0]  start_val [NUM_BARS];
        logic [6:0]  goal_val [NUM_BARS];
        logic [4:0]  step_cnt [NUM_BARS];
        logic [15:0] factor_q16 [32];
        level_rec_t  pending_levels [$];
        int unsigned mismatches;

        function new();
            for (int s = 0; s < 32; s++)
                factor_q16[s] = calc_factor(s);
            for (int i = 0; i < NUM_BARS; i++)
            begin
                start_val[i] = '0;
                goal_val[i]  = '0;
                step_cnt[i]  = '0;
            end
            mismatches = 0;
        endfunction

        // 1 - exp(-3s/STEPS) in Q0.16: Taylor series of exp(-z) with z = 3s/(16*STEPS),
        // each term truncated to Q30, then squared four times with rounding.
        function logic [15:0] calc_factor(int unsigned s);
            longint unsigned den;
            longint unsigned z;
            longint unsigned term;
            longint unsigned sum;
            longint unsigned e;
            den  = longint'(STEPS) * 16;
            z    = ((longint'(3 * s) << 30) + den / 2) / den;
            term = 64'd1 << 30;
            sum  = 64'd1 << 30;
            for (int k = 1; k <= 10; k++)
            begin
                term = ((term * z) >> 30) / k;
                if (k % 2 == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            e = sum;
            for (int k = 0; k < 4; k++)
                e = (e * e + (64'd1 << 29)) >> 30;
            e = (e + (64'd1 << 13)) >> 14;
            if (e > 65536)
                e = 65536;
            return 16'(65536 - e);
        endfunction

        // Accepted input word: loads one bar, or walks all bars on a tick
        function void take_word(logic req, logic [3:0] idx, logic [6:0] val);
            level_rec_t  rec;
            int unsigned a;
            int unsigned g;
            int unsigned f;
            int unsigned shown;
            if (req == REQ_PRESENT)
            begin
                if (idx < NUM_BARS)
                begin
                    start_val[idx] = goal_val[idx];
                    goal_val[idx]  = val;
                    step_cnt[idx]  = '0;
                end
                return;
            end
            for (int i = 0; i < NUM_BARS; i++)
            begin
                if (step_cnt[i] < STEPS)
                begin
                    f = factor_q16[step_cnt[i]];
                    a = start_val[i];
                    g = goal_val[i];
                    if (g >= a)
                        shown = a + (((g - a) * f) >> 16);
                    else
                        shown = a - (((a - g) * f) >> 16);
                    step_cnt[i] = step_cnt[i] + 5'd1;
                end
                else
                begin
                    start_val[i] = goal_val[i];
                    shown        = goal_val[i];
                end
                rec.bar   = 4'(i);
                rec.level = 4'(((shown & 8'h7F) * 8) / 90);
                rec.last  = (i == NUM_BARS - 1);
                pending_levels = {pending_levels, rec};
            end
        endfunction

        function void check_level(logic [3:0] bar, logic [3:0] level, logic last);
            level_rec_t want;
            if (pending_levels.size() == 0)
            begin
                $error("unexpected result: out_bar %0d bar_level %0d last_bar %0d",
                       bar, level, last);
                mismatches++;
                return;
            end
            want = pending_levels.pop_front();
            if (bar !== want.bar)
            begin
                $error("out_bar: expected %0d, got %0d", want.bar, bar);
                mismatches++;
            end
            if (level !== want.level)
            begin
                $error("bar_level (bar %0d): expected %0d, got %0d", want.bar, want.level, level);
                mismatches++;
            end
            if (last !== want.last)
            begin
                $error("last_bar (bar %0d): expected %0d, got %0d", want.bar, want.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic       req_type  = REQ_TICK;
    logic [3:0] bar_index = '0;
    logic [6:0] bar_value = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [3:0] out_bar;
    logic [3:0] bar_level;
    logic       last_bar;

    // When set, neither side idles: back-to-back words and no output stalls
    logic       calm = 1'b0;

    bar_anim_board board;

    spectrum_bar_easing_animator_unit #(
        .BARS (NUM_BARS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .bar_index (bar_index),
        .bar_value (bar_value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_bar   (out_bar),
        .bar_level (bar_level),
        .last_bar  (last_bar)
    );

    initial
    begin
        forever
            #2 clk = ~clk;
    end

    // Idle length: mostly none or short, now and then a long one
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 8);
        else
            return $urandom_range(15, 40);
    endfunction

    // Offer one word, hold it steady until taken, then idle for a random gap, which may be zero.
    // The valid is only lowered when a gap follows, so back-to-back words
    // never see a low/high pair in the same time step.
    task automatic push_word(input logic req, input logic [3:0] idx, input logic [6:0] val);
        int unsigned gap;
        in_valid  <= 1'b1;
        req_type  <= req;
        bar_index <= idx;
        bar_value <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        gap = calm ? 0 : gap_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Receiver back-pressure: free runs broken by stalls of random length
    initial
    begin : out_stall_gen
        int unsigned len;
        forever
        begin
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            len = calm ? 0 : gap_len();
            if (len != 0)
            begin
                out_stall <= 1'b1;
                repeat (len) @(posedge clk);
            end
        end
    end

    // Accepted words go to the predictor; accepted results are checked.
    // Both sample the values that stood just before the edge.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            board.take_word(req_type, bar_index, bar_value);
        if (rst_n && out_valid && !out_stall)
            board.check_level(out_bar, bar_level, last_bar);
    end

    // Hang guard: generous bound over the slowest legal run
    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned sent;
        int unsigned n_present;
        int unsigned n_tick;
        logic [3:0]  idx;
        logic [6:0]  val;

        board = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: tick straight out of reset (all bars at zero)
        push_word(REQ_TICK, 4'd0, 7'd0);
        // Field extremes on both end bars, and a bar set twice before a tick
        push_word(REQ_PRESENT, 4'd0, 7'd0);
        push_word(REQ_PRESENT, 4'd11, 7'd127);
        push_word(REQ_PRESENT, 4'd5, 7'd100);
        push_word(REQ_PRESENT, 4'd5, 7'd90);
        // Out-of-range bars: must be dropped without a result
        push_word(REQ_PRESENT, 4'd12, 7'd55);
        push_word(REQ_PRESENT, 4'd15, 7'd127);
        push_word(REQ_TICK, 4'd0, 7'd0);
        // Tick with its ignored fields at their maxima
        push_word(REQ_TICK, 4'd15, 7'd127);
        // Falling goal: eases downwards from the old goal
        push_word(REQ_PRESENT, 4'd11, 7'd0);
        push_word(REQ_PRESENT, 4'd3, 7'd64);
        push_word(REQ_TICK, 4'd10, 7'd42);
        push_word(REQ_TICK, 4'd0, 7'd0);
        // Run well past STEPS so bars finish and hold at their goal
        repeat (22) push_word(REQ_TICK, 4'($urandom_range(0, 15)), 7'($urandom_range(0, 127)));
        push_word(REQ_PRESENT, 4'd11, 7'd127);
        push_word(REQ_TICK, 4'd0, 7'd0);

        // Random: bursts of presents with random content, then runs of ticks,
        // long runs now and then so bars reach the end of their easing
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            if ($urandom_range(0, 99) < 15)
                calm = ~calm;
            n_present = $urandom_range(0, 6);
            for (int p = 0; p < n_present; p++)
            begin
                if ($urandom_range(0, 99) < 88)
                begin
                    idx = 4'($urandom_range(0, NUM_BARS - 1));
                    sent++;
                end
                else
                    idx = 4'($urandom_range(NUM_BARS, 15));
                case ($urandom_range(0, 9))
                    0:       val = 7'd0;
                    1:       val = 7'd127;
                    2:       val = 7'd100;
                    default: val = 7'($urandom_range(0, 127));
                endcase
                push_word(REQ_PRESENT, idx, val);
            end
            n_tick = ($urandom_range(0, 99) < 75) ? $urandom_range(1, 4)
                                                   : $urandom_range(18, 26);
            for (int t = 0; t < n_tick; t++)
            begin
                push_word(REQ_TICK, 4'($urandom_range(0, 15)), 7'($urandom_range(0, 127)));
                sent++;
            end
        end
        in_valid <= 1'b0;
        calm     = 1'b0;

        // Let every owed level arrive, then watch for strays
        while (board.pending_levels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.mismatches == 0 && board.pending_levels.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* filelist.f */
sv/seba_pkg.sv
sv/spectrum_bar_easing_animator_unit.sv
sv/seba_checker.sv
tb/sv/tb_spectrum_bar_easing_animator_unit.sv
